FILE: sv/lsm_pkg.sv
// lsm_pkg: shared types and constants for the lifo stack with max tracking
// holds the command/error codes, beat structs and cell control struct
// no dependencies

package lsm_pkg;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_INDEX     = 2'd3
  } err_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] push_value;
    logic        [5:0]  read_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic signed [31:0] max_value;
    logic        [6:0]  count;
    err_t               error;
  } res_t;

  // one stack entry plus the max of itself and everything below it
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] mx;
  } cell_t;

  typedef struct packed {
    logic push;   // every entry moves one cell deeper
    logic pop;    // every entry moves one cell toward the top
    logic load;   // copy entries into the read line
    logic shift;  // read line moves one cell toward the top
  } cell_ctl_t;

endpackage

FILE: sv/lsm_cell.sv
// lsm_cell: one position of the stack chain, entry plus read-line tap
// depends on lsm_pkg for cell_t and cell_ctl_t

module lsm_cell (
  input  logic                    clk,
  input  lsm_pkg::cell_ctl_t      ctl,
  input  lsm_pkg::cell_t          up_in,
  input  lsm_pkg::cell_t          dn_in,
  input  logic signed [31:0]      rd_dn,
  output lsm_pkg::cell_t          ent,
  output logic signed [31:0]      rd
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent <= up_in;
    end else if (ctl.pop) begin
      ent <= dn_in;
    end
    if (ctl.load) begin
      rd <= ent.value;
    end else if (ctl.shift) begin
      rd <= rd_dn;
    end
  end

endmodule

FILE: sv/lifo_stack_with_max.sv
// lifo_stack_with_max: top level, control and result register over a chain of cells
// depends on lsm_pkg and lsm_cell
//
// usage:
//   a command beat (request) is taken at a rising edge with start high and busy low.
//   push, pop, no-op and any refused command give their result beat: it
//   appears on result with done high in the cycle after start.
//   read from index i with n entries held copies the entries into a read line that
//   moves one cell toward the top each cycle until the entry reaches the top cell,
//   so latency is set by the distance (n - 1 - i) of the entry from the top.
//   busy is high while a read walks the line; start is ignored then.
//   each result sits on result for exactly one cycle marked by done; the receiver
//   has no way to stall it, so it must take every beat.
//   the top cell holds the newest entry; each cell also keeps the max of itself
//   and all older entries, so max_value needs no search.
//   after rst the stack is empty (count 0, max_value reports the most negative
//   value); entry contents are not cleared.
//   count is reported on 7 bits and read_index is 6 bits wide.

module lifo_stack_with_max #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lsm_pkg::req_t request,
  output logic          done,
  output lsm_pkg::res_t result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       hops, hops_next;
  logic                done_next;
  lsm_pkg::res_t       res_next;
  lsm_pkg::cell_ctl_t  ctl;
  lsm_pkg::cell_t      push_ent;
  lsm_pkg::cell_t      ent [DEPTH];
  logic signed [31:0]  rd  [DEPTH];
  logic signed [31:0]  below_max;
  logic                accept, full, empty, idx_bad;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      lsm_pkg::cell_t     up_in, dn_in;
      logic signed [31:0] rd_dn;
      if (g == 0) begin : g_top
        assign up_in = push_ent;
      end else begin : g_mid
        assign up_in = ent[g-1];
      end
      if (g == DEPTH - 1) begin : g_bot
        assign dn_in = '0;
        assign rd_dn = '0;
      end else begin : g_nbot
        assign dn_in = ent[g+1];
        assign rd_dn = rd[g+1];
      end
      lsm_cell u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .up_in (up_in),
        .dn_in (dn_in),
        .rd_dn (rd_dn),
        .ent   (ent[g]),
        .rd    (rd[g])
      );
    end
  endgenerate

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign empty  = (cnt == '0);
  assign full   = (cnt == CW'(DEPTH));
  assign idx_bad = (XW'(request.read_index) >= XW'(cnt));

  assign below_max = empty ? lsm_pkg::INT_MIN : ent[0].mx;

  always_comb begin
    push_ent.value = request.push_value;
    push_ent.mx    = ($signed(request.push_value) > $signed(below_max)) ?
                     request.push_value : below_max;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    hops_next  = hops;
    done_next  = 1'b0;
    ctl        = '0;
    res_next.data_out  = '0;
    res_next.max_value = below_max;
    res_next.count     = 7'(cnt);
    res_next.error     = lsm_pkg::ERR_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (request.command)
            lsm_pkg::CMD_PUSH: begin
              done_next = 1'b1;
              if (full) begin
                res_next.error = lsm_pkg::ERR_OVERFLOW;
              end else begin
                ctl.push           = 1'b1;
                cnt_next           = cnt + CW'(1);
                res_next.count     = 7'(cnt + CW'(1));
                res_next.max_value = push_ent.mx;
              end
            end
            lsm_pkg::CMD_POP: begin
              done_next = 1'b1;
              if (empty) begin
                res_next.error = lsm_pkg::ERR_UNDERFLOW;
              end else begin
                ctl.pop            = 1'b1;
                cnt_next           = cnt - CW'(1);
                res_next.count     = 7'(cnt - CW'(1));
                res_next.data_out  = ent[0].value;
                res_next.max_value = (cnt == CW'(1)) ? lsm_pkg::INT_MIN : ent[1].mx;
              end
            end
            lsm_pkg::CMD_READ: begin
              if (idx_bad) begin
                done_next      = 1'b1;
                res_next.error = lsm_pkg::ERR_INDEX;
              end else begin
                // distance of the entry from the top cell
                ctl.load   = 1'b1;
                hops_next  = cnt - CW'(1) - CW'(request.read_index);
                state_next = S_READ;
              end
            end
            lsm_pkg::CMD_NOP: begin
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (hops == '0) begin
          done_next         = 1'b1;
          res_next.data_out = rd[0];
          state_next        = S_IDLE;
        end else begin
          ctl.shift = 1'b1;
          hops_next = hops - CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
    hops   <= hops_next;
    result <= res_next;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_fast_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command != lsm_pkg::CMD_READ) |=> (done && !busy))
    else $error("single-cycle command gave no result beat");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == lsm_pkg::CMD_READ && !idx_bad) |=> (busy && !done))
    else $error("valid read did not start the read walk");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    (done && result.count == 7'd0) |-> (result.max_value == lsm_pkg::INT_MIN))
    else $error("empty stack reported a max other than the minimum");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.error != lsm_pkg::ERR_NONE) |-> (result.data_out == '0))
    else $error("error beat carried data");

endmodule
